>>> hdl/edce_pkg.sv
// ----------------------------------------------------------------------------
// edce_pkg: shared types and tables of the e-paper drive code encoder
// Operation codes, request and result structs, and the grayscale waveform.
// ----------------------------------------------------------------------------
package edce_pkg;

  localparam int unsigned FRAME_BYTES = 131072;
  localparam int unsigned ADDR_W      = $clog2(FRAME_BYTES);
  localparam int unsigned GRAY_PHASES = 9;
  localparam int unsigned PHASE_W     = 4;

  typedef enum logic [2:0] {
    OP_DARKEN   = 3'd0,
    OP_CONTRAST = 3'd1,
    OP_ZERO     = 3'd2,
    OP_PARTIAL  = 3'd3,
    OP_GRAY     = 3'd4,
    OP_COMMIT   = 3'd5
  } op_e;

  localparam logic [1:0] CODE_OFF   = 2'b00;
  localparam logic [1:0] CODE_SET   = 2'b01;
  localparam logic [1:0] CODE_CLEAR = 2'b10;
  localparam logic [1:0] CODE_HOLD  = 2'b11;

  typedef struct packed {
    logic [2:0]         op;
    logic [PHASE_W-1:0] phase;
    logic [ADDR_W-1:0]  address;
    logic [7:0]         pixel_byte;
    logic [7:0]         odd_gray_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] drive_first;
    logic [7:0] drive_second;
  } drive_t;

  localparam logic [1:0] WAVE_TABLE [8][GRAY_PHASES] = '{
    '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd1, 2'd0},
    '{2'd1, 2'd1, 2'd2, 2'd2, 2'd1, 2'd2, 2'd1, 2'd1, 2'd0},
    '{2'd0, 2'd1, 2'd2, 2'd2, 2'd1, 2'd1, 2'd2, 2'd1, 2'd0},
    '{2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd0},
    '{2'd1, 2'd2, 2'd1, 2'd2, 2'd1, 2'd1, 2'd1, 2'd2, 2'd0},
    '{2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0},
    '{2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1, 2'd2, 2'd0},
    '{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0}
  };

  function automatic logic [1:0] wave_code(input logic [2:0] level,
                                           input logic [PHASE_W-1:0] phase);
    logic [1:0] code;
    code = CODE_OFF;
    if (phase < PHASE_W'(GRAY_PHASES)) begin
      code = WAVE_TABLE[level][phase];
    end
    return code;
  endfunction

endpackage

>>> hdl/edce_if.sv
// ----------------------------------------------------------------------------
// edce_if: request and result channels of the drive code encoder
// Valid/ready channels carrying the request fields and the drive codes.
// ----------------------------------------------------------------------------
interface edce_req_if import edce_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic [PHASE_W-1:0] phase;
  logic [ADDR_W-1:0]  address;
  logic [7:0]         pixel_byte;
  logic [7:0]         odd_gray_byte;

  modport source (output valid, output op, output phase, output address,
                  output pixel_byte, output odd_gray_byte, input ready);
  modport sink   (input valid, input op, input phase, input address,
                  input pixel_byte, input odd_gray_byte, output ready);
endinterface

interface edce_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] drive_first;
  logic [7:0] drive_second;

  modport source (output valid, output drive_first, output drive_second, input ready);
  modport sink   (input valid, input drive_first, input drive_second, output ready);
endinterface

>>> hdl/edce_drive_map.sv
// ----------------------------------------------------------------------------
// edce_drive_map: drive code mapping
// Maps one request and the stored previous byte to the two drive code bytes.
// ----------------------------------------------------------------------------
module edce_drive_map import edce_pkg::*; (
  input  req_t       req_i,
  input  logic [7:0] old_byte_i,
  output drive_t     drive_o
);

  logic [15:0] codes;

  always_comb begin
    codes = '0;
    case (req_i.op)
      OP_DARKEN: begin
        for (int i = 0; i < 8; i++) begin
          codes[2*i +: 2] = req_i.pixel_byte[i] ? CODE_SET : CODE_HOLD;
        end
      end
      OP_CONTRAST: begin
        for (int i = 0; i < 8; i++) begin
          codes[2*i +: 2] = req_i.pixel_byte[i] ? CODE_SET : CODE_CLEAR;
        end
      end
      OP_PARTIAL: begin
        for (int i = 0; i < 8; i++) begin
          if (old_byte_i[i] && !req_i.pixel_byte[i]) begin
            codes[2*i +: 2] = CODE_CLEAR;
          end else if (!old_byte_i[i] && req_i.pixel_byte[i]) begin
            codes[2*i +: 2] = CODE_SET;
          end else begin
            codes[2*i +: 2] = CODE_HOLD;
          end
        end
      end
      OP_GRAY: begin
        codes[15:14] = wave_code(req_i.odd_gray_byte[2:0], req_i.phase);
        codes[13:12] = wave_code(req_i.odd_gray_byte[6:4], req_i.phase);
        codes[11:10] = wave_code(req_i.pixel_byte[2:0], req_i.phase);
        codes[9:8]   = wave_code(req_i.pixel_byte[6:4], req_i.phase);
      end
      default: begin
        codes = '0;
      end
    endcase
  end

  assign drive_o.drive_first  = codes[15:8];
  assign drive_o.drive_second = codes[7:0];

endmodule

>>> hdl/epaper_drive_code_encoder.sv
// ----------------------------------------------------------------------------
// epaper_drive_code_encoder: framebuffer byte to e-paper drive code encoder
// Turns pixel bytes into 2-bit drive codes, keeping the previous frame in RAM.
// ----------------------------------------------------------------------------
// One request is taken every clock unless rsp_o.ready stalls a held result.
// The previous-frame store is a single 128 KiB RAM with registered read: a
// request's address is read on acceptance, the next stage computes the codes
// into the result register and writes the byte back for partial and commit
// requests. A request reading the entry the stage ahead is writing gets the
// new byte forwarded. The store needs no clearing after reset; a partial
// request must only touch addresses written earlier by partial or commit.
// ----------------------------------------------------------------------------
module epaper_drive_code_encoder import edce_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  edce_req_if.sink   req_i,
  edce_rsp_if.source rsp_o
);

  logic [7:0] mem [FRAME_BYTES];

  req_t       req_in;
  req_t       s1_q;
  logic       s1_valid_q;
  logic       s1_adv;
  logic       req_acc;
  logic       mem_we;
  logic       fwd_hit;
  logic       fwd_q;
  logic [7:0] fwd_byte_q;
  logic [7:0] rd_byte_q;
  logic [7:0] old_byte;
  drive_t     drive;
  drive_t     rsp_q;
  logic       rsp_valid_q;

  assign req_in.op            = req_i.op;
  assign req_in.phase         = req_i.phase;
  assign req_in.address       = req_i.address;
  assign req_in.pixel_byte    = req_i.pixel_byte;
  assign req_in.odd_gray_byte = req_i.odd_gray_byte;

  assign s1_adv      = s1_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign req_acc     = req_i.valid && req_i.ready;
  assign mem_we      = s1_adv && (s1_q.op == OP_PARTIAL || s1_q.op == OP_COMMIT);
  assign fwd_hit     = mem_we && (s1_q.address == req_i.address);
  assign old_byte    = fwd_q ? fwd_byte_q : rd_byte_q;

  // previous-frame store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[s1_q.address] <= s1_q.pixel_byte;
    end
    if (req_acc) begin
      rd_byte_q <= mem[req_i.address];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      s1_q       <= req_in;
      fwd_byte_q <= s1_q.pixel_byte;
    end
    if (s1_adv) begin
      rsp_q <= drive;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (req_acc) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= fwd_hit;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  edce_drive_map u_drive_map (
    .req_i      (s1_q),
    .old_byte_i (old_byte),
    .drive_o    (drive)
  );

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.drive_first  = rsp_q.drive_first;
  assign rsp_o.drive_second = rsp_q.drive_second;

  a_fwd_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && fwd_hit |=> fwd_q)
    else $error("forwarding flag not set on same-address write");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> s1_valid_q)
    else $error("accepted request lost before compute stage");

  a_adv_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> rsp_valid_q)
    else $error("advanced request produced no result");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> req_i.ready)
    else $error("empty pipeline refuses requests");

endmodule
